>>> rtl/cld_pkg.sv
// Package for the circular list deque unit.
// Holds action and status codes and the payload types; no dependencies.
package cld_pkg;

  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef logic [ACTION_W-1:0]      action_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_POP_FRONT  = 3'd1;
  localparam action_t ACT_TRAVERSE   = 3'd2;
  localparam action_t ACT_PUSH_BACK  = 3'd3;
  localparam action_t ACT_POP_BACK   = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

>>> rtl/circular_list_deque_unit.sv
// Bounded double-ended queue of signed 32-bit words kept in a ring of CAPACITY
// slots. A request is taken when in_valid is high and in_stall low; the unit then
// stalls until the request is finished. Push, pop and unknown actions pass through an
// accept and an execute step and give one result; a traversal passes through accept
// and decode, then an address and a data step per stored word, and gives one result
// per stored word, front first, with out_last on the final word. Every slot address
// comes from the one ring adder, and the word store has a registered read; while
// out_stall holds a waiting result, the next result is not loaded. No clearing pass
// follows reset; slots are read only after they are written.
// Depends on cld_pkg and cld_store.
module circular_list_deque_unit #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cld_pkg::action_t  in_action,
  input  cld_pkg::word_t    in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output cld_pkg::word_t    out_word,
  output cld_pkg::status_t  out_status,
  output logic              out_last
);
  import cld_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_OP    = 2'd1;
  localparam logic [1:0] S_TADDR = 2'd2;
  localparam logic [1:0] S_TDATA = 2'd3;

  logic [1:0]       state_r, state_nxt;
  action_t          act_r;
  word_t            val_r;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_word_r, out_word_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic             k_hit;
  logic [IDX_W-1:0] ring_b;
  logic [SUM_W-1:0] ring_sum;
  logic [IDX_W-1:0] ring_pos;
  logic             load;
  word_t            load_word;
  status_t          load_status;
  logic             load_last;
  logic             mem_we;
  logic             mem_re;
  word_t            mem_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign k_hit    = ((CNT_W'({1'b0, k_r}) + CNT_W'(1)) == count_r);

  // shared ring adder
  always_comb begin
    ring_b = k_r;
    if (state_r == S_OP) begin
      unique case (act_r)
        ACT_PUSH_FRONT: ring_b = IDX_W'(CAPACITY - 1);
        ACT_POP_FRONT:  ring_b = IDX_W'(1);
        ACT_PUSH_BACK:  ring_b = count_r[IDX_W-1:0];
        default:        ring_b = k_r;
      endcase
    end
  end

  assign ring_sum = SUM_W'(front_r) + SUM_W'(ring_b);
  assign ring_pos = (ring_sum >= SUM_W'(CAPACITY)) ? IDX_W'(ring_sum - SUM_W'(CAPACITY))
                                                   : IDX_W'(ring_sum);

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    load        = 1'b0;
    load_word   = '0;
    load_status = ST_OK;
    load_last   = 1'b1;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          unique case (act_r)
            ACT_PUSH_FRONT: begin
              if (is_full) begin
                load_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                front_nxt = ring_pos;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (is_empty) begin
                load_status = ST_EMPTY;
              end else begin
                front_nxt = ring_pos;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_TRAVERSE: begin
              if (is_empty) begin
                load_status = ST_EMPTY;
              end else begin
                load      = 1'b0;
                k_nxt     = '0;
                state_nxt = S_TADDR;
              end
            end
            ACT_PUSH_BACK: begin
              if (is_full) begin
                load_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (is_empty) begin
                load_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              load_status = ST_OK;
            end
          endcase
        end
      end
      S_TADDR: begin
        mem_re    = 1'b1;
        state_nxt = S_TDATA;
      end
      S_TDATA: begin
        if (out_free) begin
          load      = 1'b1;
          load_word = mem_rdata;
          load_last = k_hit;
          if (k_hit) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_TADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = load_word;
      out_status_nxt = load_status;
      out_last_nxt   = load_last;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  cld_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ring_pos),
    .wdata (val_r),
    .re    (mem_re),
    .raddr (ring_pos),
    .rdata (mem_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> rtl/cld_store.sv
// Word store of the deque ring: one write port, one read port, registered read.
// Depends on cld_pkg for the word type.
module cld_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [ADDR_W-1:0] waddr,
  input  cld_pkg::word_t wdata,
  input  logic           re,
  input  logic [ADDR_W-1:0] raddr,
  output cld_pkg::word_t rdata
);
  import cld_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cld_checker.sv
// Port-level checks for circular_list_deque_unit, bound to the top level.
// Depends on cld_pkg for status codes.
module cld_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input cld_pkg::word_t   out_word,
  input cld_pkg::status_t out_status,
  input logic             out_last
);
  import cld_pkg::*;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("unit took a second request right after one");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_status)
      && $stable(out_last))
    else $error("stalled result changed");

  a_status_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_word == '0)
    else $error("status result not final or carries a word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_EMPTY || out_status == ST_FULL)
    else $error("undefined status code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("unit not idle after reset");

endmodule

bind circular_list_deque_unit cld_checker u_cld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_word   (out_word),
  .out_status (out_status),
  .out_last   (out_last)
);

>>> tb/sv/circular_list_deque_unit_tb.sv
// Self-checking testbench for circular_list_deque_unit: a scoreboard class predicts
// the deque results of every accepted request; a task drives requests, a process the stall.
// Depends on cld_pkg and the unit RTL.
`timescale 1ns / 100ps

module circular_list_deque_unit_tb;
  import cld_pkg::*;

  localparam int          CAPACITY        = 16;
  localparam int          RANDOM_REQUESTS = 295;
  localparam int          PRESSURE_AT     = 120;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 2 * CAPACITY + 8;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} push_bias_t;

  class deque_scoreboard;
    typedef struct {
      word_t   word;
      status_t status;
      logic    last;
    } deque_result_t;

    word_t         ring [CAPACITY];
    int            head_idx;
    int            depth;
    deque_result_t pending_q [$];
    int unsigned   requests;
    int unsigned   results_seen;
    int unsigned   traversals;
    int unsigned   full_refusals;
    int unsigned   empty_answers;
    int unsigned   mismatches;

    function new();
      head_idx = 0;
      depth    = 0;
    endfunction

    function void expect_result(word_t w, status_t s, logic l);
      deque_result_t r;
      r.word   = w;
      r.status = s;
      r.last   = l;
      pending_q.push_back(r);
      if (s == ST_FULL) full_refusals++;
      if (s == ST_EMPTY) empty_answers++;
    endfunction

    function void note_request(action_t act, word_t val);
      requests++;
      case (act)
        ACT_PUSH_FRONT: begin
          if (depth >= CAPACITY) begin
            expect_result('0, ST_FULL, 1'b1);
          end else begin
            head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
            ring[head_idx] = val;
            depth++;
            expect_result('0, ST_OK, 1'b1);
          end
        end
        ACT_POP_FRONT: begin
          if (depth == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
          end else begin
            head_idx = (head_idx + 1) % CAPACITY;
            depth--;
            expect_result('0, ST_OK, 1'b1);
          end
        end
        ACT_TRAVERSE: begin
          traversals++;
          if (depth == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
          end else begin
            for (int k = 0; k < depth; k++)
              expect_result(ring[(head_idx + k) % CAPACITY], ST_OK, k == depth - 1);
          end
        end
        ACT_PUSH_BACK: begin
          if (depth >= CAPACITY) begin
            expect_result('0, ST_FULL, 1'b1);
          end else begin
            ring[(head_idx + depth) % CAPACITY] = val;
            depth++;
            expect_result('0, ST_OK, 1'b1);
          end
        end
        ACT_POP_BACK: begin
          if (depth == 0) begin
            expect_result('0, ST_EMPTY, 1'b1);
          end else begin
            depth--;
            expect_result('0, ST_OK, 1'b1);
          end
        end
        default: begin
          expect_result('0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_result(word_t got_word, status_t got_status, logic got_last);
      deque_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word=%0d status=%0d last=%0b",
                                got_word, got_status, got_last));
        return;
      end
      want = pending_q.pop_front();
      if (got_word !== want.word || got_status !== want.status || got_last !== want.last)
        flag_mismatch($sformatf(
          "result %0d expected word=%0d status=%0d last=%0b, got word=%0d status=%0d last=%0b",
          results_seen, want.word, want.status, want.last, got_word, got_status, got_last));
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_stall;
  action_t          in_action  = ACT_PUSH_FRONT;
  word_t            in_value   = '0;
  logic             out_valid;
  logic             out_stall  = 1'b0;
  word_t            out_word;
  status_t          out_status;
  logic             out_last;

  int unsigned      cycle_count = 0;
  bit               hold_off_pending = 1'b0;
  deque_scoreboard  sb = new();

  circular_list_deque_unit #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_request(in_action, in_value);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_word, out_status, out_last);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // receiver: short stalls, a few long ones, free-running stretches, one long hold-off
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        out_stall <= 1'b0;
      end else begin
        run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(12, 30);
    if (r < 55) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic word_t pick_value();
    if ($urandom_range(0, 9) != 0) return word_t'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic action_t pick_action(push_bias_t bias);
    int unsigned r;
    int unsigned push_pct;
    r = $urandom_range(0, 99);
    if (r < 3) return action_t'(ACT_POP_BACK + $urandom_range(1, 3));
    if (r < 13) return ACT_TRAVERSE;
    case (bias)
      BIAS_FILL:  push_pct = 73;
      BIAS_DRAIN: push_pct = 40;
      default:    push_pct = 56;
    endcase
    if (r < push_pct) return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  // hold the request until taken; valid stays high when the next one follows at once
  task automatic send_request(action_t act, word_t val, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  initial begin
    push_bias_t bias;
    bit         quiet;
    bias  = BIAS_EVEN;
    quiet = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_TRAVERSE, '0, 0);
    send_request(ACT_POP_FRONT, '1, 0);
    send_request(ACT_POP_BACK, 32'sh5A5A_5A5A, 1);
    send_request(ACT_POP_BACK + 3'd1, 32'sh1234_5678, 0);
    send_request(ACT_POP_BACK + 3'd2, '0, 0);
    send_request(ACT_POP_BACK + 3'd3, '1, 2);
    send_request(ACT_PUSH_FRONT, 32'sh8000_0000, 0);
    send_request(ACT_PUSH_BACK, 32'sh7FFF_FFFF, 0);
    for (int k = 0; k < CAPACITY - 2; k++)
      send_request((k % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                   (k == 0) ? '1 : (k == 1) ? '0 : word_t'($urandom), pick_gap());
    send_request(ACT_PUSH_FRONT, 32'sh0BAD_F00D, 0);
    send_request(ACT_PUSH_BACK, 32'sh7FFF_FFFF, 0);
    send_request(ACT_TRAVERSE, '0, 0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) begin
        bias  = push_bias_t'($urandom_range(0, 2));
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (n == PRESSURE_AT) begin
        hold_off_pending = 1'b1;
        bias  = BIAS_FILL;
        quiet = 1'b1;
      end
      send_request(pick_action(bias), pick_value(), quiet ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d traversals) and checked %0d results;",
             sb.requests, sb.traversals, sb.results_seen);
    $display("%0d refused pushes, %0d empty answers, %0d mismatches.",
             sb.full_refusals, sb.empty_answers, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cld_pkg.sv
rtl/cld_store.sv
rtl/circular_list_deque_unit.sv
rtl/cld_checker.sv
tb/sv/circular_list_deque_unit_tb.sv
